[rtl/sid_pkg.sv]
// Shared types for the signed integer divider.
// Depends on nothing; compile first.
package sid_pkg;

	// Control bits that travel with each operand pair down the pipeline
	typedef struct packed {
		logic valid;
		logic neg;
		logic dbz;
	} stage_ctl_t;

endpackage

[rtl/sid_in_if.sv]
// Operand channel of the signed integer divider: valid/ready plus payload.
// Depends on nothing.
interface sid_in_if #(
	parameter int WIDTH = 32
);
	logic                    valid;
	logic                    ready;
	logic signed [WIDTH-1:0] dividend;
	logic signed [WIDTH-1:0] divisor;

	modport source (output valid, output dividend, output divisor, input ready);
	modport sink (input valid, input dividend, input divisor, output ready);
endinterface

[rtl/sid_out_if.sv]
// Result channel of the signed integer divider: valid/ready plus payload.
// Depends on nothing.
interface sid_out_if #(
	parameter int WIDTH = 32
);
	logic                    valid;
	logic                    ready;
	logic signed [WIDTH-1:0] quotient;
	logic                    divide_by_zero;

	modport source (output valid, output quotient, output divide_by_zero, input ready);
	modport sink (input valid, input quotient, input divide_by_zero, output ready);
endinterface

[rtl/sid_step.sv]
// One restoring division stage: retires one quotient bit per pass.
// Depends on sid_pkg.
module sid_step #(
	parameter int WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  sid_pkg::stage_ctl_t ctl_in,
	input  logic [WIDTH-1:0]   rem_in,
	input  logic [WIDTH-1:0]   nq_in,
	input  logic [WIDTH-1:0]   den_in,
	output sid_pkg::stage_ctl_t ctl_out,
	output logic [WIDTH-1:0]   rem_out,
	output logic [WIDTH-1:0]   nq_out,
	output logic [WIDTH-1:0]   den_out
);
	import sid_pkg::*;

	logic [WIDTH:0]   trial;
	logic [WIDTH:0]   diff;
	logic             fits;
	stage_ctl_t       ctl_s1;
	logic [WIDTH-1:0] rem_s1;
	logic [WIDTH-1:0] nq_s1;
	logic [WIDTH-1:0] den_s1;

	// Shift the next dividend bit into the partial remainder, try the subtract
	always_comb begin
		trial = {rem_in, nq_in[WIDTH-1]};
		diff  = trial - {1'b0, den_in};
		fits  = (trial >= {1'b0, den_in});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
			nq_s1  <= {nq_in[WIDTH-2:0], fits};
			den_s1 <= den_in;
		end
	end

	assign ctl_out = ctl_s1;
	assign rem_out = rem_s1;
	assign nq_out  = nq_s1;
	assign den_out = den_s1;
endmodule

[rtl/signed_integer_divider.sv]
// Top level of the pipelined signed integer divider.
// Depends on sid_pkg, sid_in_if, sid_out_if and sid_step.
//
//  channel    dir   payload                         transfer when
//  operands   in    dividend, divisor (signed)      valid & ready
//  result     out   quotient (signed), divide_by_zero  valid & ready
//
// Each operand pair passes from transfer to result through one setup stage,
// one restoring stage per quotient bit, and one sign fix-up stage that also
// feeds the output register. A new pair may enter in every cycle while the
// pipeline is not held. Reset clears the control bits only. When the output
// register is full and not taken, the whole pipeline holds, so nothing is lost or repeated.
module signed_integer_divider #(
	parameter int DATA_WIDTH = 32
) (
	input logic      clk,
	input logic      arst_n,
	sid_in_if.sink   operands,
	sid_out_if.source result
);
	import sid_pkg::*;

	localparam int W = DATA_WIDTH;

	// Global advance: move everything on unless the held result is stuck
	logic en;

	// Setup stage
	stage_ctl_t ctl_s1;
	logic [W-1:0] nmag_s1;
	logic [W-1:0] dmag_s1;

	// Stage chain: index i feeds step i, index W is the last step's output
	stage_ctl_t   ctl_w [0:W];
	logic [W-1:0] rem_w [0:W];
	logic [W-1:0] nq_w  [0:W];
	logic [W-1:0] den_w [0:W];

	// Output register
	logic         out_valid_q;
	logic [W-1:0] quotient_q;
	logic         dbz_q;
	logic [W-1:0] fixed_q;

	assign en             = !out_valid_q || result.ready;
	assign operands.ready = en;

	// Form the magnitudes; the most negative value maps to 2^(W-1) exactly
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.valid <= operands.valid;
			ctl_s1.neg   <= operands.dividend[W-1] ^ operands.divisor[W-1];
			ctl_s1.dbz   <= (operands.divisor == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nmag_s1 <= operands.dividend[W-1] ? (~operands.dividend + 1'b1)
				: operands.dividend;
			dmag_s1 <= operands.divisor[W-1] ? (~operands.divisor + 1'b1)
				: operands.divisor;
		end
	end

	assign ctl_w[0] = ctl_s1;
	assign rem_w[0] = '0;
	assign nq_w[0]  = nmag_s1;
	assign den_w[0] = dmag_s1;

	// One stage per quotient bit, most significant first
	for (genvar i = 0; i < W; i++) begin : g_step
		sid_step #(
			.WIDTH (W)
		) u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.ctl_in  (ctl_w[i]),
			.rem_in  (rem_w[i]),
			.nq_in   (nq_w[i]),
			.den_in  (den_w[i]),
			.ctl_out (ctl_w[i+1]),
			.rem_out (rem_w[i+1]),
			.nq_out  (nq_w[i+1]),
			.den_out (den_w[i+1])
		);
	end

	// Sign fix-up: zero on a zero divisor, negate when signs differ,
	// saturate the single overflow case (most negative by minus one)
	always_comb begin
		if (ctl_w[W].dbz) begin
			fixed_q = '0;
		end else if (ctl_w[W].neg) begin
			fixed_q = ~nq_w[W] + 1'b1;
		end else if (nq_w[W][W-1]) begin
			fixed_q = {1'b0, {(W-1){1'b1}}};
		end else begin
			fixed_q = nq_w[W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= ctl_w[W].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quotient_q <= fixed_q;
			dbz_q      <= ctl_w[W].dbz;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.quotient       = quotient_q;
	assign result.divide_by_zero = dbz_q;
endmodule
